FILE: rtl/core/mkmr_pkg.sv
// Package with payload types, codes and helpers for the multi-key match retrieval table.
`timescale 1ns / 1ps
package mkmr_pkg;

    // Input word of one key item.
    typedef struct packed {
        logic        mode;
        logic [63:0] key;
        logic        key_valid;
        logic        last;
        logic [15:0] data_length;
    } t_in_word;

    // Output word of one result.
    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [5:0]  entry_index;
        logic [39:0] entry_offset;
        logic [15:0] entry_length;
        logic [3:0]  score;
        logic [3:0]  entry_key_count;
        logic        result_last;
    } t_out_word;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    localparam logic MODE_WRITE = 1'b0;

    localparam logic [1:0] REG_MAX_RESULTS = 2'd0;
    localparam logic [1:0] REG_DATA_MAX    = 2'd1;

    localparam int THR_NUM = 40;
    localparam int THR_ADD = 99;
    localparam int THR_DEN = 100;

    // Control handed from the sequencer to the cell chain and the hit sorter.
    typedef struct packed {
        logic write_en;
        logic score_en;
        logic shift_en;
    } t_chain_ctl;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_SCORE,
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

endpackage

FILE: rtl/core/mkmr_cell.sv
// One table cell: stores an entry, scores it against the query keys and takes part in the hit sort.
`timescale 1ns / 1ps
module mkmr_cell #(
    parameter int MAX_KEYS = 8,
    parameter int KEY_BITS = 64,
    parameter int CW       = 5
) (
    input  logic                          i_clk,
    input  logic                          i_wr,
    input  logic [MAX_KEYS-1:0][KEY_BITS-1:0] i_keys,
    input  logic [CW-1:0]                 i_kcnt,
    input  logic [39:0]                   i_off,
    input  logic [15:0]                   i_len,
    input  logic [MAX_KEYS-1:0][KEY_BITS-1:0] i_q,
    input  logic [CW-1:0]                 i_qcnt,
    input  logic                          i_score,
    output logic [CW-1:0]                 o_score,
    output logic [CW-1:0]                 o_kcnt,
    output logic [39:0]                   o_off,
    output logic [15:0]                   o_len
);

    logic [MAX_KEYS-1:0][KEY_BITS-1:0] r_keys;
    logic [CW-1:0] r_kcnt;
    logic [39:0]   r_off;
    logic [15:0]   r_len;
    logic [CW-1:0] r_score;
    logic [CW-1:0] n_score;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_keys <= i_keys;
            r_kcnt <= i_kcnt;
            r_off  <= i_off;
            r_len  <= i_len;
        end
        if (i_score) begin
            r_score <= n_score;
        end
    end

    // Count query keys found among the stored keys.
    always_comb begin
        logic hit;
        n_score = '0;
        for (int i = 0; i < MAX_KEYS; i++) begin
            hit = 1'b0;
            for (int j = 0; j < MAX_KEYS; j++) begin
                if (CW'(j) < r_kcnt && r_keys[j] == i_q[i]) begin
                    hit = 1'b1;
                end
            end
            if (CW'(i) < i_qcnt && hit) begin
                n_score = n_score + CW'(1);
            end
        end
    end

    assign o_score = r_score;
    assign o_kcnt  = r_kcnt;
    assign o_off   = r_off;
    assign o_len   = r_len;

endmodule

FILE: rtl/core/mkmr_sorter.sv
// Hit list as a rotating chain of slots that picks hits in exchange-sort order.
`timescale 1ns / 1ps
module mkmr_sorter #(
    parameter int N  = 64,
    parameter int IW = 6,
    parameter int CW = 5
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic [N-1:0][CW-1:0] i_scores,
    input  logic [N-1:0]         i_hit,
    input  logic                 i_step,
    input  logic                 i_take,
    output logic                 o_any,
    output logic [IW-1:0]        o_idx,
    output logic [CW-1:0]        o_score,
    output logic                 o_left
);

    // Each slot holds valid, index and score. A head register plays the part
    // of the current sort position. Every step moves slot 0 past the head and
    // around to the tail; a strictly better slot trades places with the head,
    // exactly like one compare-exchange of the sort. Once every slot has
    // passed the head, the chain is back in place and the head holds the
    // next hit in sorted order. An empty head counts as lower than every hit.
    logic [N-1:0]         r_v;
    logic [N-1:0][IW-1:0] r_i;
    logic [N-1:0][CW-1:0] r_s;
    logic                 r_hv;
    logic [IW-1:0]        r_hi;
    logic [CW-1:0]        r_hs;
    logic                 swap;

    assign swap = r_v[0] && (!r_hv || r_s[0] > r_hs);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < N; k++) begin
                r_v[k] <= i_hit[k];
                r_i[k] <= IW'(k);
                r_s[k] <= i_scores[k];
            end
            r_hv <= 1'b0;
            r_hi <= '0;
            r_hs <= '0;
        end else if (i_step) begin
            r_v <= {(swap ? r_hv : r_v[0]), r_v[N-1:1]};
            r_i <= {(swap ? r_hi : r_i[0]), r_i[N-1:1]};
            r_s <= {(swap ? r_hs : r_s[0]), r_s[N-1:1]};
            if (swap) begin
                r_hv <= r_v[0];
                r_hi <= r_i[0];
                r_hs <= r_s[0];
            end
        end else if (i_take) begin
            r_hv <= 1'b0;
        end
    end

    assign o_any   = r_hv;
    assign o_idx   = r_hi;
    assign o_score = r_hs;
    assign o_left  = |r_v;

endmodule

FILE: rtl/core/multi_key_match_retrieval.sv
// Top level of the multi-key match retrieval table.
// Channel | Direction | Word
// in      | input     | mkmr_pkg::t_in_word, i_in_valid / o_in_stall
// out     | output    | mkmr_pkg::t_out_word, o_out_valid / i_out_stall
// cfg     | input     | APB write/read of max_results and data_max
// The acknowledge word of a write end sits in the output register on the next cycle.
// A query end passes a scoring state and a load state, then for each returned word
// one pass around the hit chain and one output state, which waits while the output
// is stalled.
// Reset clears entry count, data end, pending count and the sequencer.
// The output register holds a result while stalled; input is stalled meanwhile.
`timescale 1ns / 1ps
module multi_key_match_retrieval #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_KEYS    = 8,
    parameter int KEY_BITS    = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mkmr_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mkmr_pkg::t_out_word  o_out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CW = $clog2(MAX_KEYS + 1) + 1;
    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int PW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    logic [6:0]  r_max_results;
    logic [15:0] r_data_max;
    logic [EW-1:0] r_count;
    logic [39:0] r_data_end;
    logic [MAX_KEYS-1:0][KEY_BITS-1:0] r_pend;
    logic [CW-1:0] r_pcnt;
    mkmr_pkg::t_state r_state, n_state;
    logic r_ov, n_ov;
    mkmr_pkg::t_out_word r_ow, n_ow;
    logic [6:0] r_emitted, n_emitted;
    logic [IW-1:0] r_rot, n_rot;
    logic [CW-1:0] r_thr;
    mkmr_pkg::t_chain_ctl ctl;

    logic [MAX_ENTRIES-1:0][CW-1:0] c_score, c_kcnt;
    logic [MAX_ENTRIES-1:0][39:0]   c_off;
    logic [MAX_ENTRIES-1:0][15:0]   c_len;
    logic [MAX_ENTRIES-1:0]         c_hit;
    logic [15:0] clen;

    logic [MAX_KEYS-1:0][KEY_BITS-1:0] n_pend;
    logic [CW-1:0] n_pcnt;
    logic acc;

    logic s_any;
    logic [IW-1:0] s_idx;
    logic [CW-1:0] s_score;
    logic s_load;
    logic s_take;
    logic s_left;

    logic [6:0] thr_raw;
    logic out_free;
    logic hit_last;
    logic [15:0] hlen;

    // Configuration port.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_results <= 7'd64;
            r_data_max    <= 16'd4096;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == mkmr_pkg::REG_DATA_MAX[0]) begin
                r_data_max <= pwdata[15:0];
            end else begin
                r_max_results <= pwdata[6:0];
            end
        end
    end
    assign prdata = (paddr[2] == mkmr_pkg::REG_DATA_MAX[0])
                    ? {16'd0, r_data_max} : {25'd0, r_max_results};

    // Cell chain.
    assign clen = (i_in_word.data_length > r_data_max) ? r_data_max : i_in_word.data_length;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        mkmr_cell #(.MAX_KEYS(MAX_KEYS), .KEY_BITS(KEY_BITS), .CW(CW)) u_cell (
            .i_clk  (i_clk),
            .i_wr   (ctl.write_en && r_count == EW'(g)),
            .i_keys (n_pend),
            .i_kcnt (n_pcnt),
            .i_off  (r_data_end),
            .i_len  (clen),
            .i_q    (r_pend),
            .i_qcnt (r_pcnt),
            .i_score(ctl.score_en),
            .o_score(c_score[g]),
            .o_kcnt (c_kcnt[g]),
            .o_off  (c_off[g]),
            .o_len  (c_len[g])
        );
        assign c_hit[g] = (EW'(g) < r_count) && (c_score[g] >= r_thr);
    end

    mkmr_sorter #(.N(MAX_ENTRIES), .IW(IW), .CW(CW)) u_sort (
        .i_clk   (i_clk),
        .i_load  (s_load),
        .i_scores(c_score),
        .i_hit   (c_hit),
        .i_step  (ctl.shift_en),
        .i_take  (s_take),
        .o_any   (s_any),
        .o_idx   (s_idx),
        .o_score (s_score),
        .o_left  (s_left)
    );

    // Pending key collection including the current item.
    assign acc = i_in_valid && !o_in_stall;
    always_comb begin
        n_pend = r_pend;
        n_pcnt = r_pcnt;
        if (i_in_word.key_valid && r_pcnt < CW'(MAX_KEYS)) begin
            n_pend[r_pcnt[PW-1:0]] = i_in_word.key[KEY_BITS-1:0];
            n_pcnt = r_pcnt + CW'(1);
        end
    end

    // Hit threshold for each possible key count, worked out at elaboration.
    always_comb begin
        thr_raw = '0;
        for (int i = 0; i <= MAX_KEYS; i++) begin
            if (n_pcnt == CW'(i)) begin
                thr_raw = 7'((i * mkmr_pkg::THR_NUM + mkmr_pkg::THR_ADD)
                             / mkmr_pkg::THR_DEN);
            end
        end
    end

    // Hit length clamped below data_max.
    assign hlen = (c_len[s_idx] >= r_data_max)
                  ? ((r_data_max != 16'd0) ? r_data_max - 16'd1 : 16'd0) : c_len[s_idx];

    // A hit word is the last one when the limit is reached or no hit is left.
    assign hit_last = (r_emitted + 7'd1 >= r_max_results) || !s_left;

    // Sequencer and output word.
    assign out_free = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != mkmr_pkg::ST_COLLECT) || !out_free;
    always_comb begin
        n_state   = r_state;
        ctl       = '0;
        s_load    = 1'b0;
        s_take    = 1'b0;
        n_ov      = r_ov && i_out_stall;
        n_ow      = r_ow;
        n_emitted = r_emitted;
        n_rot     = r_rot;
        unique case (r_state)
            mkmr_pkg::ST_COLLECT: begin
                if (acc && i_in_word.last) begin
                    if (i_in_word.mode == mkmr_pkg::MODE_WRITE) begin
                        ctl.write_en = (r_count < EW'(MAX_ENTRIES));
                        n_ov = 1'b1;
                        n_ow = '0;
                        n_ow.kind = mkmr_pkg::KIND_WRITE;
                        n_ow.result_last = 1'b1;
                        if (ctl.write_en) begin
                            n_ow.entry_index     = 6'(r_count);
                            n_ow.entry_offset    = r_data_end;
                            n_ow.entry_length    = clen;
                            n_ow.entry_key_count = 4'(n_pcnt);
                        end else begin
                            n_ow.status = 1'b1;
                        end
                    end else begin
                        n_state = mkmr_pkg::ST_SCORE;
                    end
                end
            end
            mkmr_pkg::ST_SCORE: begin
                ctl.score_en = 1'b1;
                n_state = mkmr_pkg::ST_LOAD;
            end
            mkmr_pkg::ST_LOAD: begin
                s_load    = 1'b1;
                n_emitted = '0;
                n_rot     = '0;
                n_state   = mkmr_pkg::ST_SORT;
            end
            mkmr_pkg::ST_SORT: begin
                ctl.shift_en = 1'b1;
                n_rot = r_rot + IW'(1);
                if (r_rot == IW'(MAX_ENTRIES - 1)) begin
                    n_state = mkmr_pkg::ST_EMIT;
                end
            end
            mkmr_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ow = '0;
                    n_emitted = r_emitted + 7'd1;
                    if (!s_any || r_max_results == 7'd0) begin
                        n_ow.kind        = mkmr_pkg::KIND_NONE;
                        n_ow.result_last = 1'b1;
                        n_state = mkmr_pkg::ST_COLLECT;
                    end else begin
                        n_ow.kind            = mkmr_pkg::KIND_HIT;
                        n_ow.entry_index     = 6'(s_idx);
                        n_ow.entry_offset    = c_off[s_idx];
                        n_ow.entry_length    = hlen;
                        n_ow.score           = 4'(s_score);
                        n_ow.entry_key_count = 4'(c_kcnt[s_idx]);
                        n_ow.result_last     = hit_last;
                        s_take = 1'b1;
                        n_rot  = '0;
                        n_state = hit_last ? mkmr_pkg::ST_COLLECT : mkmr_pkg::ST_SORT;
                    end
                end
            end
            default: n_state = mkmr_pkg::ST_COLLECT;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mkmr_pkg::ST_COLLECT;
            r_count    <= '0;
            r_data_end <= '0;
            r_pcnt     <= '0;
            r_ov       <= 1'b0;
            r_emitted  <= '0;
            r_rot      <= '0;
        end else begin
            r_state   <= n_state;
            r_ov      <= n_ov;
            r_ow      <= n_ow;
            r_emitted <= n_emitted;
            r_rot     <= n_rot;
            if (ctl.write_en) begin
                r_count    <= r_count + EW'(1);
                r_data_end <= r_data_end + 40'(clen);
            end
            if (acc) begin
                r_pend <= n_pend;
                r_thr  <= (thr_raw > 7'd1) ? CW'(thr_raw) : CW'(1);
            end
            if (acc && i_in_word.last && i_in_word.mode == mkmr_pkg::MODE_WRITE) begin
                r_pcnt <= '0;
            end else if (acc) begin
                r_pcnt <= n_pcnt;
            end else if (r_state == mkmr_pkg::ST_LOAD) begin
                r_pcnt <= '0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_ow;

`ifndef SYNTHESIS
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= EW'(MAX_ENTRIES)) else $error("entry count overflow");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mkmr_pkg::ST_COLLECT) |-> o_in_stall) else $error("input open");
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= CW'(MAX_KEYS)) else $error("pending overflow");
`endif

endmodule
